/* rtl/core/text_grid_layout_macros.svh */
// Assertion helpers used by the checker file of the text grid layout block.
`ifndef TEXT_GRID_LAYOUT_MACROS_SVH
`define TEXT_GRID_LAYOUT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TGL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_grid_layout check failed");

// Next-cycle implication, disabled while reset is low.
`define TGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text_grid_layout check failed");

// Holds in the cycle after any cycle with reset low.
`define TGL_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("text_grid_layout reset check failed");

`endif

/* rtl/core/tgl_pkg.sv */
`timescale 1ns / 1ps
package tgl_pkg;

    localparam int unsigned CFG_COLS_W  = 6;
    localparam int unsigned CFG_LINES_W = 4;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [CFG_COLS_W-1:0]  COLS_RESET  = 6'd21;
    localparam logic [CFG_LINES_W-1:0] LINES_RESET = 4'd8;

    localparam logic [7:0] PRINT_FIRST = 8'h20;
    localparam logic [7:0] PRINT_LAST  = 8'h7E;
    localparam logic [7:0] TEXT_END    = 8'h00;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register select: address bit 2 picks the 32-bit word.
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_LINES   = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;

    typedef struct packed {
        logic       op;
        logic [7:0] text_byte;
        logic [2:0] read_line;
        logic [4:0] read_column;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] stored_count;
        logic               string_done;
        logic               was_stored;
        logic [CHAR_W-1:0]  cell_value;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] stored_count;
        logic               string_done;
        logic               was_stored;
    } resp_t;

    typedef enum logic [1:0] {
        CMD_REPORT,
        CMD_READ,
        CMD_WRITE,
        CMD_CLEAR
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_CLEAR,
        BK_RESP
    } back_state_t;

endpackage

/* rtl/core/tgl_queue.sv */
`timescale 1ns / 1ps
module tgl_queue
    import tgl_pkg::*;
#(
    parameter type cmd_t = logic
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    cmd_t                   slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign full    = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QUEUE_PTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QUEUE_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/tgl_front.sv */
`timescale 1ns / 1ps
module tgl_front
    import tgl_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS   = 32,
    parameter int unsigned LINE_CAPACITY = 8,
    parameter type cmd_t = logic,
    localparam int unsigned COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int unsigned ACT_COL_W = $clog2(MAX_COLUMNS + 1),
    localparam int unsigned LINE_W    = $clog2(LINE_CAPACITY + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    input  logic [ACT_COL_W-1:0] act_cols,
    input  logic [LINE_W-1:0]    act_lines,
    input  logic                 init_busy,
    input  logic                 q_full,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic [LINE_W-1:0]    cur_line_reg;
    logic [LINE_W-1:0]    cur_line_next;
    logic [COL_W-1:0]     cur_col_reg;
    logic [COL_W-1:0]     cur_col_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [LINE_W-1:0]    line_n;
    logic [COL_W-1:0]     col_n;
    logic [ACT_COL_W-1:0] col_inc;
    logic [COUNT_W-1:0]   count_inc;

    assign s_ready = !q_full && !init_busy;
    assign push    = s_valid && s_ready;

    // Normalize a cursor left past a lowered column limit.
    always_comb begin
        line_n = cur_line_reg;
        col_n  = cur_col_reg;
        if ((cur_line_reg < act_lines) && (ACT_COL_W'(cur_col_reg) >= act_cols)) begin
            line_n = cur_line_reg + LINE_W'(1);
            col_n  = '0;
        end
        col_inc   = ACT_COL_W'(col_n) + ACT_COL_W'(1);
        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    end

    // Classify the item and build the command for the back end.
    always_comb begin
        push_cmd                   = '0;
        push_cmd.kind              = CMD_REPORT;
        push_cmd.resp.stored_count = count_reg;
        cur_line_next              = cur_line_reg;
        cur_col_next               = cur_col_reg;
        count_next                 = count_reg;
        if (s_item.op == OP_READ) begin
            push_cmd.kind  = CMD_READ;
            push_cmd.rd_ok = (32'(s_item.read_line) < LINE_CAPACITY)
                          && (32'(s_item.read_column) < MAX_COLUMNS);
            push_cmd.line  = LINE_W'(s_item.read_line);
            push_cmd.col   = COL_W'(s_item.read_column);
        end else begin
            cur_line_next = line_n;
            cur_col_next  = col_n;
            if (s_item.text_byte == TEXT_END) begin
                push_cmd.kind             = CMD_CLEAR;
                push_cmd.line             = line_n;
                push_cmd.col              = col_n;
                push_cmd.stop_line        = act_lines;
                push_cmd.resp.string_done = 1'b1;
                cur_line_next             = '0;
                cur_col_next              = '0;
                count_next                = '0;
            end else if (line_n >= act_lines) begin
                push_cmd.kind = CMD_REPORT;
            end else if (s_item.text_byte inside {[PRINT_FIRST:PRINT_LAST]}) begin
                push_cmd.kind              = CMD_WRITE;
                push_cmd.line              = line_n;
                push_cmd.col               = col_n;
                push_cmd.char_code         = s_item.text_byte[CHAR_W-1:0];
                push_cmd.resp.was_stored   = 1'b1;
                push_cmd.resp.stored_count = count_inc;
                count_next                 = count_inc;
                if (col_inc >= act_cols) begin
                    cur_col_next  = '0;
                    cur_line_next = line_n + LINE_W'(1);
                end else begin
                    cur_col_next = COL_W'(col_inc);
                end
            end else begin
                push_cmd.kind      = CMD_CLEAR;
                push_cmd.line      = line_n;
                push_cmd.col       = col_n;
                push_cmd.stop_line = line_n + LINE_W'(1);
                cur_col_next       = '0;
                cur_line_next      = line_n + LINE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_line_reg <= '0;
            cur_col_reg  <= '0;
            count_reg    <= '0;
        end else if (push) begin
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            count_reg    <= count_next;
        end
    end

endmodule

/* rtl/core/tgl_back.sv */
`timescale 1ns / 1ps
module tgl_back
    import tgl_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS   = 32,
    parameter int unsigned LINE_CAPACITY = 8,
    parameter type cmd_t = logic,
    localparam int unsigned COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int unsigned ACT_COL_W = $clog2(MAX_COLUMNS + 1),
    localparam int unsigned LINE_W    = $clog2(LINE_CAPACITY + 1),
    localparam int unsigned DEPTH     = LINE_CAPACITY * MAX_COLUMNS,
    localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  cmd_t                 q_cmd,
    output logic                 pop,
    input  logic [ACT_COL_W-1:0] act_cols,
    output logic                 init_busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [ADDR_W-1:0]   init_addr_reg;
    logic [LINE_W-1:0]   walk_line_reg;
    logic [COL_W-1:0]    walk_col_reg;
    logic [LINE_W-1:0]   stop_line_reg;
    resp_t               resp_reg;
    logic                rd_ok_reg;
    logic [CHAR_W-1:0]   mem [DEPTH];
    logic [CHAR_W-1:0]   cell_q_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    out_item_t           m_item_reg;

    logic                out_free;
    logic                walk_more;
    logic [ACT_COL_W-1:0] walk_col_inc;
    logic                init_last;
    logic                load_out;
    out_item_t           out_item;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CHAR_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] line,
                                                     input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(line) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
    endfunction

    assign out_free     = !m_valid_reg || m_ready;
    assign walk_more    = walk_line_reg < stop_line_reg;
    assign walk_col_inc = ACT_COL_W'(walk_col_reg) + ACT_COL_W'(1);
    assign init_last    = (init_addr_reg == ADDR_W'(DEPTH - 1));
    assign init_busy    = (state_reg == BK_INIT);
    assign m_valid      = m_valid_reg;
    assign m_item       = m_item_reg;
    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_INIT: begin
                if (init_last) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!q_empty && out_free) begin
                    case (q_cmd.kind)
                        CMD_READ:  state_next = BK_READ;
                        CMD_CLEAR: state_next = BK_CLEAR;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_READ: state_next = BK_IDLE;
            BK_CLEAR: begin
                if (!walk_more) begin
                    state_next = BK_RESP;
                end
            end
            BK_RESP: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_INIT;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        load_out  = 1'b0;
        out_item  = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            BK_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = init_addr_reg;
            end
            BK_IDLE: begin
                if (!q_empty && out_free) begin
                    pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_WRITE: begin
                            mem_we                = 1'b1;
                            mem_waddr             = cell_addr(q_cmd.line, q_cmd.col);
                            mem_wdata             = q_cmd.char_code;
                            load_out              = 1'b1;
                            out_item.stored_count = q_cmd.resp.stored_count;
                            out_item.was_stored   = q_cmd.resp.was_stored;
                        end
                        CMD_READ: begin
                            mem_re    = q_cmd.rd_ok;
                            mem_raddr = cell_addr(q_cmd.line, q_cmd.col);
                        end
                        CMD_REPORT: begin
                            load_out              = 1'b1;
                            out_item.stored_count = q_cmd.resp.stored_count;
                        end
                        default: ;
                    endcase
                end
            end
            BK_READ: begin
                load_out              = 1'b1;
                out_item.stored_count = resp_reg.stored_count;
                out_item.cell_value   = rd_ok_reg ? cell_q_reg : '0;
            end
            BK_CLEAR: begin
                if (walk_more) begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(walk_line_reg, walk_col_reg);
                end
            end
            BK_RESP: begin
                if (out_free) begin
                    load_out              = 1'b1;
                    out_item.stored_count = resp_reg.stored_count;
                    out_item.string_done  = resp_reg.string_done;
                    out_item.was_stored   = resp_reg.was_stored;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_INIT;
            init_addr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == BK_INIT) begin
                init_addr_reg <= init_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            resp_reg      <= q_cmd.resp;
            rd_ok_reg     <= q_cmd.rd_ok;
            walk_line_reg <= q_cmd.line;
            walk_col_reg  <= q_cmd.col;
            stop_line_reg <= q_cmd.stop_line;
        end else if ((state_reg == BK_CLEAR) && walk_more) begin
            if (walk_col_inc >= act_cols) begin
                walk_col_reg  <= '0;
                walk_line_reg <= walk_line_reg + LINE_W'(1);
            end else begin
                walk_col_reg <= COL_W'(walk_col_inc);
            end
        end
        if (load_out) begin
            m_item_reg <= out_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            cell_q_reg <= mem[mem_raddr];
        end
    end

endmodule

/* rtl/core/text_grid_layout.sv */
// Rate: one printable byte per cycle while s_ready is high and m_ready keeps up; a cell
//   read holds the grid engine in its read state before it takes the next command; clears
//   are walked one cell per cycle through the single write port of the grid memory.
// Reset (aresetn low, synchronous): cursor, count and queue clear, registers return to 21
//   columns and 8 lines, then s_ready stays low while the grid memory is blanked.
`timescale 1ns / 1ps
module text_grid_layout
    import tgl_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS   = 32,
    parameter int unsigned LINE_CAPACITY = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input item channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // Result item channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int unsigned ACT_COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned LINE_W    = $clog2(LINE_CAPACITY + 1);

    // Command handed from the classifier to the grid engine. A clear walks from
    // (line, col) up to the start of stop_line; a read carries its cell in line/col.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [LINE_W-1:0]   line;
        logic [COL_W-1:0]    col;
        logic [LINE_W-1:0]   stop_line;
        logic [CHAR_W-1:0]   char_code;
        logic                rd_ok;
        resp_t               resp;
    } cmd_t;

    logic [CFG_COLS_W-1:0]  cols_reg;
    logic [CFG_LINES_W-1:0] lines_reg;
    logic                   cfg_wr;
    logic [ACT_COL_W-1:0]   act_cols;
    logic [LINE_W-1:0]      act_lines;

    logic                   init_busy;
    logic                   q_full;
    logic                   q_empty;
    logic                   push;
    logic                   pop;
    cmd_t                   push_cmd;
    cmd_t                   pop_cmd;

    // Register port: zero wait states; only address bit 2 selects the word.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= COLS_RESET;
            lines_reg <= LINES_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_COLUMNS: cols_reg  <= pwdata[CFG_COLS_W-1:0];
                REG_LINES:   lines_reg <= pwdata[CFG_LINES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_COLUMNS: prdata = {{(APB_DATA_W-CFG_COLS_W){1'b0}}, cols_reg};
            REG_LINES:   prdata = {{(APB_DATA_W-CFG_LINES_W){1'b0}}, lines_reg};
            default:     prdata = '0;
        endcase
    end

    // Clamp the programmed sizes into the grid: zero acts as one, too large acts as max.
    always_comb begin
        if (cols_reg == '0) begin
            act_cols = ACT_COL_W'(1);
        end else if (32'(cols_reg) > MAX_COLUMNS) begin
            act_cols = ACT_COL_W'(MAX_COLUMNS);
        end else begin
            act_cols = ACT_COL_W'(cols_reg);
        end
        if (lines_reg == '0) begin
            act_lines = LINE_W'(1);
        end else if (32'(lines_reg) > LINE_CAPACITY) begin
            act_lines = LINE_W'(LINE_CAPACITY);
        end else begin
            act_lines = LINE_W'(lines_reg);
        end
    end

    // Front: accept items, track the cursor and count, and turn each item into one
    // grid command. It runs ahead of the grid engine by up to the queue depth.
    tgl_front #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .LINE_CAPACITY (LINE_CAPACITY),
        .cmd_t         (cmd_t)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .act_cols  (act_cols),
        .act_lines (act_lines),
        .init_busy (init_busy),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Short command queue: lets the front keep taking bytes while a clear walks.
    tgl_queue #(
        .cmd_t (cmd_t)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: owns the grid memory, blanks it after reset, executes writes, reads and
    // clear walks in order, and holds each result in the output register.
    tgl_back #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .LINE_CAPACITY (LINE_CAPACITY),
        .cmd_t         (cmd_t)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .pop       (pop),
        .act_cols  (act_cols),
        .init_busy (init_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

/* rtl/core/tgl_checker.sv */
`timescale 1ns / 1ps
`include "text_grid_layout_macros.svh"
module tgl_checker
    import tgl_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A stalled result holds.
    `TGL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // End of string never stores a byte or carries a cell.
    `TGL_ASSERT_IMPL(a_done_clean, aclk, aresetn, m_valid && m_item.string_done, !m_item.was_stored && (m_item.cell_value == '0))

    // A stored byte always leaves a nonzero count.
    `TGL_ASSERT_IMPL(a_store_counts, aclk, aresetn, m_valid && m_item.was_stored, m_item.stored_count != '0)

    // Input closed while the grid is blanked after reset.
    `TGL_ASSERT_AFTER_RESET(a_reset_blocks, aclk, aresetn, !s_ready)

    // No result straight out of reset.
    `TGL_ASSERT_AFTER_RESET(a_reset_quiet, aclk, aresetn, !m_valid)

endmodule

bind text_grid_layout tgl_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
